// ===== rtl/teleop_velocity_profile_shaper_core_assert.svh =====
// Assertion macros for the top-level core, which checks its own logic.
`ifndef TELEOP_VELOCITY_PROFILE_SHAPER_CORE_ASSERT_SVH
`define TELEOP_VELOCITY_PROFILE_SHAPER_CORE_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define TVPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define TVPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tvps_pkg.sv =====
package tvps_pkg;

    localparam int CURVE_ENTRIES     = 64;
    localparam int DEFAULT_PERIOD_MS = 100;
    localparam int IDX_W             = $clog2(CURVE_ENTRIES);
    localparam int DIVCNT_W          = $clog2(IDX_W + 1);

    localparam logic [63:0] ONE_Q28 = 64'd1 << 28;
    localparam logic [63:0] PI_Q28  = 64'd843314857;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] axis_forward;
        logic signed [15:0] axis_turn;
        logic [9:0]         elapsed_ms;
        logic               front_blocked;
        logic               left_zone_blocked;
        logic               right_zone_blocked;
        logic               near_left;
        logic               near_right;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] linear_velocity;
        logic signed [15:0] angular_velocity;
        logic               linear_braking;
        logic               turn_braking;
    } out_item_t;

    typedef struct packed {
        logic [15:0] forward_gain;
        logic [15:0] reverse_gain;
        logic [15:0] turn_gain;
        logic [15:0] accel_window_ms;
        logic [15:0] brake_window_ms;
        logic [14:0] deadzone;
        logic [14:0] turn_step;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_FORWARD_GAIN = 3'd0,
        REG_REVERSE_GAIN = 3'd1,
        REG_TURN_GAIN    = 3'd2,
        REG_ACCEL_WINDOW = 3'd3,
        REG_BRAKE_WINDOW = 3'd4,
        REG_DEADZONE     = 3'd5,
        REG_TURN_STEP    = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JOY,
        ST_FILTER,
        ST_DIV,
        ST_MUL_CURVE,
        ST_PROFILE,
        ST_MUL_LIN,
        ST_MUL_ANG,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_CURVE,
        MUL_LIN,
        MUL_ANG
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     joy;
        logic     filter;
        logic     div_step;
        mul_sel_t mul_sel;
        logic     prod_load;
        logic     profile;
        logic     lin_load;
        logic     ang_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    typedef logic [CURVE_ENTRIES-1:0][15:0] curve_t;

    // Shift-subtract division, elaboration use only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_q28(input logic [63:0] a);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = ONE_Q28;
        term = ONE_Q28;
        for (int n = 1; n < 40; n++) begin
            if (term != 0) begin
                term = udiv64((term * a) >> 28, 64'(n));
                sum  = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] cos_q28(input logic [63:0] t);
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        t2   = (t * t) >> 28;
        term = ONE_Q28;
        sum  = $signed(ONE_Q28);
        for (int k = 1; k < 20; k++) begin
            if (term != 0) begin
                term = udiv64((term * t2) >> 28, 64'((2 * k - 1) * (2 * k)));
                if ((k % 2) == 1) sum = sum - $signed(term);
                else              sum = sum + $signed(term);
            end
        end
        if (sum < 0) sum = '0;
        if (sum > $signed(ONE_Q28)) sum = $signed(ONE_Q28);
        return 64'(sum);
    endfunction

    function automatic curve_t build_sigmoid();
        curve_t      tbl;
        logic [63:0] d;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] top;
        for (int i = 0; i < CURVE_ENTRIES; i++) begin
            d   = (2 * i >= CURVE_ENTRIES) ? 64'(2 * i - CURVE_ENTRIES)
                                           : 64'(CURVE_ENTRIES - 2 * i);
            a   = udiv64((64'd5 * d) << 28, 64'(2 * CURVE_ENTRIES));
            e   = exp_q28(a);
            den = ONE_Q28 + e;
            top = (2 * i >= CURVE_ENTRIES) ? e : ONE_Q28;
            tbl[i] = 16'(udiv64((top << 15) + (den >> 1), den));
        end
        return tbl;
    endfunction

    function automatic curve_t build_cosine();
        curve_t      tbl;
        logic [63:0] c;
        logic [63:0] c2;
        for (int i = 0; i < CURVE_ENTRIES; i++) begin
            c  = cos_q28(udiv64(PI_Q28 * 64'(i), 64'(2 * CURVE_ENTRIES)));
            c2 = (c * c) >> 28;
            tbl[i] = 16'(((c2 << 15) + (64'd1 << 27)) >> 28);
        end
        return tbl;
    endfunction

    localparam curve_t SIGMOID_TABLE = build_sigmoid();
    localparam curve_t COSINE_TABLE  = build_cosine();

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767)       return 16'sh7fff;
        else if (v < -20'sd32768) return 16'sh8000;
        else                      return v[15:0];
    endfunction

endpackage

// ===== rtl/tvps_ctrl.sv =====
module tvps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_is_tick,
    input  tvps_pkg::status_t status,
    output logic             in_stall,
    output tvps_pkg::cmd_t   cmd
);
    import tvps_pkg::*;

    state_t              state_reg, state_next;
    logic [DIVCNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_CURVE;
        in_stall    = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = in_is_tick ? ST_FILTER : ST_JOY;
                end
            end
            ST_JOY:
            begin
                cmd.joy    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FILTER:
            begin
                cmd.filter = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIVCNT_W'(IDX_W - 1)) state_next = ST_MUL_CURVE;
            end
            ST_MUL_CURVE:
            begin
                cmd.mul_sel   = MUL_CURVE;
                cmd.prod_load = 1'b1;
                state_next    = ST_PROFILE;
            end
            ST_PROFILE:
            begin
                cmd.profile = 1'b1;
                state_next  = ST_MUL_LIN;
            end
            ST_MUL_LIN:
            begin
                cmd.mul_sel  = MUL_LIN;
                cmd.lin_load = 1'b1;
                state_next   = ST_MUL_ANG;
            end
            ST_MUL_ANG:
            begin
                cmd.mul_sel  = MUL_ANG;
                cmd.ang_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/tvps_dp.sv =====
module tvps_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  tvps_pkg::cfg_t      cfg,
    input  tvps_pkg::in_item_t  in_data,
    input  tvps_pkg::cmd_t      cmd,
    input  logic                out_stall,
    output tvps_pkg::status_t   status,
    output logic                out_valid,
    output tvps_pkg::out_item_t out_data
);
    import tvps_pkg::*;

    in_item_t           item_reg;
    logic signed [15:0] held_f_reg, held_t_reg, prev_f_reg, prev_t_reg;
    logic signed [15:0] fprof_reg, tprof_reg, start_reg;
    logic signed [15:0] des_f_reg, des_t_reg;
    logic [16:0]        ramp_reg;
    logic [9:0]         elapsed_reg;
    logic               fbrake_reg, tbrake_reg;
    logic [16:0]        rem_reg;
    logic [15:0]        window_reg;
    logic [IDX_W-1:0]   quot_reg;
    logic signed [18:0] prod_reg;
    logic signed [15:0] lin_reg, ang_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    // Joystick axes with deadzone
    logic signed [15:0] neg_turn, joy_f, joy_t;
    logic [16:0]        mag_f, mag_t;

    always_comb
    begin
        neg_turn = (item_reg.axis_turn == 16'sh8000) ? 16'sh7fff : -item_reg.axis_turn;
        mag_f    = item_reg.axis_forward[15] ? 17'(-{item_reg.axis_forward[15],
                                                     item_reg.axis_forward})
                                             : 17'({1'b0, item_reg.axis_forward});
        mag_t    = neg_turn[15] ? 17'(-{neg_turn[15], neg_turn}) : 17'({1'b0, neg_turn});
        joy_f    = (mag_f < 17'(cfg.deadzone)) ? '0 : item_reg.axis_forward;
        joy_t    = (mag_t < 17'(cfg.deadzone)) ? '0 : neg_turn;
    end

    // Tick command filter
    logic signed [15:0] flt_f, flt_t;

    always_comb
    begin
        flt_f = held_f_reg;
        flt_t = held_t_reg;
        if ((prev_f_reg > 0 && flt_f < 0) || (prev_f_reg < 0 && flt_f > 0)) flt_f = '0;
        if ((prev_t_reg > 0 && flt_t < 0) || (prev_t_reg < 0 && flt_t > 0)) flt_t = '0;
        if (flt_t > 0 && (item_reg.near_left || item_reg.left_zone_blocked)) flt_t = '0;
        if (flt_t < 0 && (item_reg.near_right || item_reg.right_zone_blocked)) flt_t = '0;
        if (item_reg.front_blocked && flt_f > 0) flt_f = '0;
    end

    // Index divider step: one quotient bit a cycle
    logic [17:0] rem_dbl;
    logic        q_bit;

    always_comb
    begin
        rem_dbl = {rem_reg, 1'b0};
        q_bit   = (rem_dbl >= 18'(window_reg));
    end

    // Shared Q1.15 multiplier, rounding half away from zero
    logic signed [17:0] mul_v;
    logic [15:0]        mul_g;
    logic [16:0]        mul_mag;
    logic [32:0]        mul_raw;
    logic [17:0]        mul_rnd;
    logic signed [18:0] mul_res;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_CURVE:
            begin
                if (fbrake_reg)
                begin
                    mul_v = 18'(start_reg);
                    mul_g = COSINE_TABLE[quot_reg];
                end
                else
                begin
                    mul_v = 18'(des_f_reg) - 18'(start_reg);
                    mul_g = SIGMOID_TABLE[quot_reg];
                end
            end
            MUL_LIN:
            begin
                mul_v = 18'(fprof_reg);
                mul_g = fprof_reg[15] ? cfg.reverse_gain : cfg.forward_gain;
            end
            MUL_ANG:
            begin
                mul_v = 18'(tprof_reg);
                mul_g = cfg.turn_gain;
            end
            default:
            begin
                mul_v = '0;
                mul_g = '0;
            end
        endcase
        mul_mag = mul_v[17] ? 17'(-mul_v) : mul_v[16:0];
        mul_raw = 33'(mul_mag) * 33'(mul_g) + 33'd16384;
        mul_rnd = mul_raw[32:15];
        mul_res = mul_v[17] ? -$signed({1'b0, mul_rnd}) : $signed({1'b0, mul_rnd});
    end

    // Profile update
    logic signed [15:0] fp_n, tp_n, start_n;
    logic [16:0]        ramp_n;
    logic               fb_n, tb_n;
    logic signed [16:0] step_s;
    logic [16:0]        tmag;
    logic signed [17:0] tdelta;
    logic [17:0]        dmag;

    always_comb
    begin
        fp_n    = fprof_reg;
        start_n = start_reg;
        ramp_n  = ramp_reg;
        fb_n    = fbrake_reg;
        tp_n    = tprof_reg;
        tb_n    = tbrake_reg;
        step_s  = $signed({2'b00, cfg.turn_step});
        tmag    = tprof_reg[15] ? 17'(-{tprof_reg[15], tprof_reg}) : 17'({1'b0, tprof_reg});
        tdelta  = 18'(des_t_reg) - 18'(tprof_reg);
        dmag    = tdelta[17] ? 18'(-tdelta) : 18'(tdelta);

        if (fbrake_reg)
        begin
            if (ramp_reg < 17'(cfg.brake_window_ms))
            begin
                fp_n   = sat16(20'(prod_reg));
                ramp_n = ramp_reg + 17'(elapsed_reg);
            end
            else
            begin
                fp_n    = '0;
                fb_n    = 1'b0;
                ramp_n  = '0;
                start_n = '0;
            end
        end
        else if (des_f_reg != fprof_reg)
        begin
            if (ramp_reg < 17'(cfg.accel_window_ms))
            begin
                fp_n   = sat16(20'(start_reg) + 20'(prod_reg));
                ramp_n = ramp_reg + 17'(elapsed_reg);
            end
            else
            begin
                fp_n    = des_f_reg;
                ramp_n  = '0;
                start_n = des_f_reg;
            end
        end
        else
        begin
            ramp_n  = '0;
            start_n = fprof_reg;
        end

        if (des_f_reg == 0 && fp_n != 0 && !fb_n)
        begin
            fb_n    = 1'b1;
            start_n = fp_n;
            ramp_n  = '0;
        end
        else if (des_f_reg != 0 && fb_n)
        begin
            fb_n    = 1'b0;
            start_n = fp_n;
            ramp_n  = '0;
        end

        if (tbrake_reg)
        begin
            if (tmag > 17'(cfg.turn_step))
                tp_n = (tprof_reg > 0) ? 16'(17'(tprof_reg) - step_s)
                                       : 16'(17'(tprof_reg) + step_s);
            else
            begin
                tp_n = '0;
                tb_n = 1'b0;
            end
        end
        else if (des_t_reg != tprof_reg)
        begin
            if (dmag > 18'(cfg.turn_step))
                tp_n = tdelta[17] ? 16'(17'(tprof_reg) - step_s)
                                  : 16'(17'(tprof_reg) + step_s);
            else
                tp_n = des_t_reg;
        end

        if (des_t_reg == 0 && tp_n != 0 && !tb_n) tb_n = 1'b1;
        else if (des_t_reg != 0 && tb_n)          tb_n = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_f_reg    <= '0;
            held_t_reg    <= '0;
            prev_f_reg    <= '0;
            prev_t_reg    <= '0;
            fprof_reg     <= '0;
            tprof_reg     <= '0;
            start_reg     <= '0;
            ramp_reg      <= '0;
            fbrake_reg    <= 1'b0;
            tbrake_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.joy)
            begin
                held_f_reg <= joy_f;
                held_t_reg <= joy_t;
            end
            if (cmd.filter)
            begin
                held_f_reg <= flt_f;
                held_t_reg <= flt_t;
                prev_f_reg <= flt_f;
                prev_t_reg <= flt_t;
            end
            if (cmd.profile)
            begin
                fprof_reg  <= fp_n;
                tprof_reg  <= tp_n;
                start_reg  <= start_n;
                ramp_reg   <= ramp_n;
                fbrake_reg <= fb_n;
                tbrake_reg <= tb_n;
            end
            if (cmd.out_load)                   out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture) item_reg <= in_data;
        if (cmd.filter)
        begin
            des_f_reg   <= flt_f;
            des_t_reg   <= flt_t;
            elapsed_reg <= (item_reg.elapsed_ms == '0) ? 10'(DEFAULT_PERIOD_MS)
                                                       : item_reg.elapsed_ms;
            rem_reg     <= ramp_reg;
            window_reg  <= fbrake_reg ? cfg.brake_window_ms : cfg.accel_window_ms;
            quot_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= q_bit ? 17'(rem_dbl - 18'(window_reg)) : rem_dbl[16:0];
            quot_reg <= {quot_reg[IDX_W-2:0], q_bit};
        end
        if (cmd.prod_load) prod_reg <= mul_res;
        if (cmd.lin_load)  lin_reg  <= sat16(20'(mul_res));
        if (cmd.ang_load)  ang_reg  <= sat16(20'(mul_res));
        if (cmd.out_load)
        begin
            out_reg.linear_velocity  <= lin_reg;
            out_reg.angular_velocity <= ang_reg;
            out_reg.linear_braking   <= fbrake_reg;
            out_reg.turn_braking     <= tbrake_reg;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule

// ===== rtl/teleop_velocity_profile_shaper_core.sv =====
// Velocity profile shaper for a teleoperated base. Joystick beats (operation 0)
// store the deadzoned forward axis and the negated turn axis and give no result;
// each stalls the input through its store state.
// Tick beats (operation 1) filter the held commands against sign reversal and
// blocked zones, advance the forward profile along a sigmoid acceleration or
// cosine braking curve, slew the turn profile by turn_step, and give one result
// beat with the gain-scaled velocities. After a tick is accepted, one state
// filters the commands, a bit-serial divider forms the curve index (one bit
// per cycle for a 64-entry curve), and then come three passes through one
// shared 17x16 multiplier, the profile update and the output load. One beat
// is in work at a time; a new beat is taken while a finished result still
// waits in the output register, and a tick that finishes while that result
// is still stalled holds until it leaves. Configuration registers sit on the
// APB port at byte address 4*index and should be written only while the
// block is idle.
module teleop_velocity_profile_shaper_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  tvps_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tvps_pkg::out_item_t out_data
);
    import tvps_pkg::*;

`include "teleop_velocity_profile_shaper_core_assert.svh"

    cfg_t     cfg_reg;
    cmd_t     cmd;
    status_t  status;
    reg_idx_t widx;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[4:2]);

    // Register file: write on the access phase, ignore indexes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.forward_gain    <= 16'd32768;
            cfg_reg.reverse_gain    <= 16'd13107;
            cfg_reg.turn_gain       <= 16'd9830;
            cfg_reg.accel_window_ms <= 16'd3000;
            cfg_reg.brake_window_ms <= 16'd1000;
            cfg_reg.deadzone        <= 15'd1638;
            cfg_reg.turn_step       <= 15'd3277;
        end
        else if (wr_en)
        begin
            unique case (widx)
                REG_FORWARD_GAIN: cfg_reg.forward_gain    <= pwdata[15:0];
                REG_REVERSE_GAIN: cfg_reg.reverse_gain    <= pwdata[15:0];
                REG_TURN_GAIN:    cfg_reg.turn_gain       <= pwdata[15:0];
                REG_ACCEL_WINDOW: cfg_reg.accel_window_ms <= pwdata[15:0];
                REG_BRAKE_WINDOW: cfg_reg.brake_window_ms <= pwdata[15:0];
                REG_DEADZONE:     cfg_reg.deadzone        <= pwdata[14:0];
                REG_TURN_STEP:    cfg_reg.turn_step       <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read back: unlisted addresses read as zero
    always_comb
    begin
        unique case (widx)
            REG_FORWARD_GAIN: prdata = 32'(cfg_reg.forward_gain);
            REG_REVERSE_GAIN: prdata = 32'(cfg_reg.reverse_gain);
            REG_TURN_GAIN:    prdata = 32'(cfg_reg.turn_gain);
            REG_ACCEL_WINDOW: prdata = 32'(cfg_reg.accel_window_ms);
            REG_BRAKE_WINDOW: prdata = 32'(cfg_reg.brake_window_ms);
            REG_DEADZONE:     prdata = 32'(cfg_reg.deadzone);
            REG_TURN_STEP:    prdata = 32'(cfg_reg.turn_step);
            default:          prdata = '0;
        endcase
    end

    tvps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_is_tick (in_data.operation),
        .status     (status),
        .in_stall   (in_stall),
        .cmd        (cmd)
    );

    tvps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // A taken beat keeps the input stalled while it is worked on
    `TVPS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy")
    // Loading a result always shows it next cycle
    `TVPS_ASSERT_NEXT(a_out_after_load, cmd.out_load, out_valid, "result load lost")
    // Never overwrite a result that is still stalled
    `TVPS_ASSERT_SAME(a_no_overwrite, cmd.out_load, !(out_valid && out_stall), "result overwritten")

endmodule
